// File: rtl/dsssd_pkg.sv
// Package for the decimal seven-segment shift driver.
// Holds chain sizing, command codes, segment tables and shared types.
// Depends on nothing; every other file in rtl uses it.
package dsssd_pkg;

    localparam int CHAIN_BITS = 32;
    localparam int MAX_OUT    = 32;
    localparam int N_OUT      = (CHAIN_BITS > MAX_OUT) ? MAX_OUT :
                                ((CHAIN_BITS < 1) ? 1 : CHAIN_BITS);
    localparam int LEFT_W     = $clog2(N_OUT + 1);

    localparam int WORD_W  = 32;
    localparam int NUM_W   = 16;
    localparam int DIGIT_W = 4;
    localparam int BCD_W   = 3 * DIGIT_W;
    localparam int STEP_W  = $clog2(NUM_W);

    localparam logic CMD_RAW    = 1'b0;
    localparam logic CMD_NUMBER = 1'b1;

    typedef enum logic [1:0] {
        S_EMPTY,
        S_CONV,
        S_FULL
    } t_conv_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // Hundreds and units displays: PCDE--------GFAB
    function automatic logic [15:0] seg_hi(input logic [DIGIT_W-1:0] digit);
        logic [15:0] pat;
        unique case (digit)
            4'd0:    pat = 16'h7007;
            4'd1:    pat = 16'h4001;
            4'd2:    pat = 16'h300B;
            4'd3:    pat = 16'h600B;
            4'd4:    pat = 16'h400D;
            4'd5:    pat = 16'h600E;
            4'd6:    pat = 16'h700E;
            4'd7:    pat = 16'h4003;
            4'd8:    pat = 16'h700F;
            4'd9:    pat = 16'h600F;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

    // Tens display: ----PCDEGFAB----
    function automatic logic [15:0] seg_mid(input logic [DIGIT_W-1:0] digit);
        logic [15:0] pat;
        unique case (digit)
            4'd0:    pat = 16'h0770;
            4'd1:    pat = 16'h0410;
            4'd2:    pat = 16'h03B0;
            4'd3:    pat = 16'h06B0;
            4'd4:    pat = 16'h04D0;
            4'd5:    pat = 16'h06E0;
            4'd6:    pat = 16'h07E0;
            4'd7:    pat = 16'h0430;
            4'd8:    pat = 16'h07F0;
            4'd9:    pat = 16'h06F0;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/dsssd_if.sv
// Stream interfaces of the decimal seven-segment shift driver.
// Input channel carries one command; output channel one serial bit.
// Depends on dsssd_pkg for field widths.
interface dsssd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [dsssd_pkg::WORD_W-1:0]  raw_word;
    logic [dsssd_pkg::NUM_W-1:0]   number;

    modport source (output valid, output command, output raw_word, output number,
                    input ready);
    modport sink   (input valid, input command, input raw_word, input number,
                    output ready);
endinterface

interface dsssd_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch_after;

    modport source (output valid, output serial_bit, output latch_after, input ready);
    modport sink   (input valid, input serial_bit, input latch_after, output ready);
endinterface

// File: rtl/dsssd_conv.sv
// Front stage: takes a command, converts a number to three BCD digits by
// shift-and-add-3 (one bit a cycle), and holds the segment word for the chain.
// Depends on dsssd_pkg and dsssd_if.
module dsssd_conv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dsssd_in_if.sink                     i_in,
    input  logic                         i_take,
    output logic                         o_word_valid,
    output logic [dsssd_pkg::WORD_W-1:0] o_word
);

    dsssd_pkg::t_conv_state r_state, n_state;

    logic                          r_cmd;
    logic [dsssd_pkg::WORD_W-1:0]  r_raw;
    logic [dsssd_pkg::NUM_W-1:0]   r_num;
    logic [dsssd_pkg::BCD_W-1:0]   r_bcd;
    logic [dsssd_pkg::STEP_W-1:0]  r_step;

    logic                          accept;
    logic                          last_step;
    logic [dsssd_pkg::BCD_W-1:0]   bcd_adj;

    assign accept    = i_in.valid && i_in.ready;
    assign last_step = (r_step == dsssd_pkg::STEP_W'(dsssd_pkg::NUM_W - 1));

    // Add 3 to each digit of 5 or more before the shift.
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            if (r_bcd[d*dsssd_pkg::DIGIT_W +: dsssd_pkg::DIGIT_W] >= 4'd5) begin
                bcd_adj[d*dsssd_pkg::DIGIT_W +: dsssd_pkg::DIGIT_W] =
                    r_bcd[d*dsssd_pkg::DIGIT_W +: dsssd_pkg::DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[d*dsssd_pkg::DIGIT_W +: dsssd_pkg::DIGIT_W] =
                    r_bcd[d*dsssd_pkg::DIGIT_W +: dsssd_pkg::DIGIT_W];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsssd_pkg::S_EMPTY: begin
                if (accept) begin
                    n_state = (i_in.command == dsssd_pkg::CMD_NUMBER) ?
                              dsssd_pkg::S_CONV : dsssd_pkg::S_FULL;
                end
            end
            dsssd_pkg::S_CONV: begin
                if (last_step) begin
                    n_state = dsssd_pkg::S_FULL;
                end
            end
            dsssd_pkg::S_FULL: begin
                if (accept) begin
                    n_state = (i_in.command == dsssd_pkg::CMD_NUMBER) ?
                              dsssd_pkg::S_CONV : dsssd_pkg::S_FULL;
                end else if (i_take) begin
                    n_state = dsssd_pkg::S_EMPTY;
                end
            end
            default: n_state = dsssd_pkg::S_EMPTY;
        endcase
    end

    // Outputs
    always_comb begin
        i_in.ready   = 1'b0;
        o_word_valid = 1'b0;
        unique case (r_state)
            dsssd_pkg::S_EMPTY: i_in.ready = 1'b1;
            dsssd_pkg::S_CONV:  i_in.ready = 1'b0;
            dsssd_pkg::S_FULL: begin
                o_word_valid = 1'b1;
                i_in.ready   = i_take;
            end
            default: i_in.ready = 1'b0;
        endcase
    end

    always_comb begin
        if (r_cmd == dsssd_pkg::CMD_NUMBER) begin
            o_word = {dsssd_pkg::seg_hi(r_bcd[11:8]), 16'h0000}
                   | {16'h0000, dsssd_pkg::seg_mid(r_bcd[7:4])}
                   | {16'h0000, dsssd_pkg::seg_hi(r_bcd[3:0])};
        end else begin
            o_word = r_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsssd_pkg::S_EMPTY;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_step <= '0;
            end else if (r_state == dsssd_pkg::S_CONV) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Payload: load on transfer, then shift the number into the digits.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in.command;
            r_raw <= i_in.raw_word;
            r_num <= i_in.number;
            r_bcd <= '0;
        end else if (r_state == dsssd_pkg::S_CONV) begin
            r_bcd <= {bcd_adj[dsssd_pkg::BCD_W-2:0], r_num[dsssd_pkg::NUM_W-1]};
            r_num <= {r_num[dsssd_pkg::NUM_W-2:0], 1'b0};
        end
    end

endmodule

// File: rtl/dsssd_cell.sv
// One bit cell of the shift chain: loads a word bit or takes its neighbor's bit.
// Depends on dsssd_pkg for the control struct.
module dsssd_cell (
    input  logic                  i_clk,
    input  dsssd_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_load_bit,
    input  logic                  i_next_bit,
    output logic                  o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bit <= i_load_bit;
        end else if (i_ctl.shift) begin
            r_bit <= i_next_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: rtl/decimal_seven_segment_shift_driver_top.sv
// Top level of the decimal seven-segment shift driver.
// Instantiates dsssd_conv and a row of dsssd_cell; uses dsssd_pkg and dsssd_if.
//
//   channel | dir | fields                          | one transfer
//   --------+-----+---------------------------------+------------------------------
//   i_in    | in  | command, raw_word[31:0],        | one raw word or one number
//           |     | number[15:0]                    |
//   o_out   | out | serial_bit, latch_after         | one bit of the word, LSB first
//
// Each item gives 32 output transfers, one a cycle while o_out is not stalled;
// the chain length sets the sustained rate.
// A number is converted in the front stage one binary bit a cycle, hidden
// behind the previous item's shifting; a raw word is ready in the cycle after its transfer.
// Reset (synchronous, active low) empties the front stage and the chain.
// A stall on o_out holds the chain; the front stage keeps one word waiting and
// accepts the next item in the cycle the chain takes that word.
module decimal_seven_segment_shift_driver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsssd_in_if.sink    i_in,
    dsssd_out_if.source o_out
);

    localparam int N = dsssd_pkg::N_OUT;

    // Front stage handshake toward the chain.
    logic                         word_valid;
    logic [dsssd_pkg::WORD_W-1:0] word;
    logic                         take;

    // Bits left to send of the item now in the chain.
    logic [dsssd_pkg::LEFT_W-1:0] r_left;

    logic                         out_xfer;
    logic                         chain_free;
    dsssd_pkg::t_cell_ctl         cell_ctl;
    logic [N-1:0]                 cell_bit;
    logic [N-1:0]                 cell_next;

    dsssd_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_take       (take),
        .o_word_valid (word_valid),
        .o_word       (word)
    );

    assign out_xfer   = o_out.valid && o_out.ready;
    // The chain is free when empty or when its last bit leaves this cycle.
    assign chain_free = (r_left == '0)
                     || ((r_left == dsssd_pkg::LEFT_W'(1)) && out_xfer);
    assign take       = chain_free && word_valid;

    assign cell_ctl.load  = take;
    assign cell_ctl.shift = out_xfer;

    // Row of cells: cell 0 drives the output, each cell takes its upper neighbor.
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == N - 1) begin : g_end
            assign cell_next[g] = 1'b0;
        end else begin : g_mid
            assign cell_next[g] = cell_bit[g+1];
        end

        dsssd_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_load_bit (word[g]),
            .i_next_bit (cell_next[g]),
            .o_bit      (cell_bit[g])
        );
    end

    // Count down one per output transfer; reload on take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (take) begin
            r_left <= dsssd_pkg::LEFT_W'(N);
        end else if (out_xfer) begin
            r_left <= r_left - 1'b1;
        end
    end

    assign o_out.valid       = (r_left != '0);
    assign o_out.serial_bit  = cell_bit[0];
    // Mark the final bit so the latch pulse follows it.
    assign o_out.latch_after = (r_left == dsssd_pkg::LEFT_W'(1));

endmodule
